// ===== rtl/lru_cache_with_miss_lock_defines.svh =====
// assertion helpers for the top-level rtl file
`ifndef LRU_CACHE_WITH_MISS_LOCK_DEFINES_SVH
`define LRU_CACHE_WITH_MISS_LOCK_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LRUC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lruc assertion failed");

// next-cycle implication, checked outside reset
`define LRUC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lruc assertion failed");

`endif

// ===== rtl/lruc_pkg.sv =====
`default_nettype none
package lruc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDW   = 31;
  localparam int TIMEW = 32;
  localparam int CAPW  = 5;
  localparam int LATW  = 16;
  localparam int IDXW  = 1;
  localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
  // width for comparing capacity against cell positions
  localparam int CMPW  = (CNTW > CAPW) ? CNTW : CAPW;

  localparam logic [IDXW-1:0] REG_CAPACITY = 1'd0;
  localparam logic [IDXW-1:0] REG_LATENCY  = 1'd1;

  localparam logic [1:0] ST_HIT    = 2'd0;
  localparam logic [1:0] ST_FETCH  = 2'd1;
  localparam logic [1:0] ST_REFUSE = 2'd2;

  localparam logic [CAPW-1:0] CAP_RESET = 5'd16;
  localparam logic [LATW-1:0] LAT_RESET = 16'd100;

  typedef struct packed {
    logic           look;   // compare key against stored id
    logic [IDW-1:0] key;
    logic           upd;    // apply move-to-front or insert
    logic           fetch;  // insert rather than move
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lruc_cell.sv =====
`default_nettype none
module lruc_cell (
  input  wire                            clk,
  input  wire                            rst,
  input  lruc_pkg::cell_ctl_t            ctl,
  input  wire                            take,
  input  wire                            cap_ok,
  input  wire  [lruc_pkg::IDW-1:0]       prev_id,
  input  wire                            prev_valid,
  output logic [lruc_pkg::IDW-1:0]       id,
  output logic                           valid,
  output logic                           match
);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.look) begin
        match <= valid && (id == ctl.key);
      end
      if (ctl.upd && take && ctl.fetch) begin
        // entries pushed past the capacity drop out
        valid <= prev_valid && cap_ok;
      end
    end
  end

  // payload takes the neighbor's id on a shift
  always_ff @(posedge clk) begin
    if (ctl.upd && take) begin
      id <= prev_id;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lru_cache_with_miss_lock.sv =====
`default_nettype none
`include "lru_cache_with_miss_lock_defines.svh"
// Fully associative LRU cache of content ids with a lock on the backing
// memory after each fetch. The entries sit in a row of cells ordered by
// recency, most recent in cell 0; a hit moves its entry to the front and
// a fetch pushes the whole row down by one, dropping what falls past the
// capacity. In the accept cycle every cell compares its id against the
// key; in the update state the row shifts and the result is loaded into
// the output register. The result register holds a finished word while
// the next request is accepted; if it is still occupied when the next
// result is due, the update waits for it. The cache comes out of reset
// empty, with no clearing pass. The user must write capacity and latency
// (wr_en/wr_index/wr_data) only while the block idles; it is not enforced.
module lru_cache_with_miss_lock (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire                           mode,
  input  wire  [lruc_pkg::IDW-1:0]      lookup_id,
  input  wire  [lruc_pkg::TIMEW-1:0]    now,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [1:0]                    status,
  output logic [lruc_pkg::TIMEW-1:0]    ready_time,
  input  wire                           wr_en,
  input  wire  [lruc_pkg::IDXW-1:0]     wr_index,
  input  wire  [lruc_pkg::LATW-1:0]     wr_data
);

  localparam int N = lruc_pkg::MAX_ENTRIES;
  localparam int CMPW = lruc_pkg::CMPW;
  localparam int TW = lruc_pkg::TIMEW;

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t                        state;
  logic [lruc_pkg::CAPW-1:0]     capacity;
  logic [lruc_pkg::LATW-1:0]     fetch_latency;
  logic [TW-1:0]                 lock_until;
  logic                          req_mode;
  logic [lruc_pkg::IDW-1:0]      req_id;
  logic [TW-1:0]                 req_now;

  lruc_pkg::cell_ctl_t           ctl;
  logic [N-1:0]                  match_vec;
  logic [N-1:0]                  valid_vec;
  logic [N-1:0]                  seen;
  logic [N-1:0]                  cap_ok;
  logic [lruc_pkg::IDW-1:0]      id_vec [N];

  logic                          accept;
  logic                          out_free;
  logic                          hit;
  logic                          refuse;
  logic                          load;
  logic [TW:0]                   end_sum;
  logic [TW-1:0]                 lock_end;
  logic [CMPW-1:0]               cap_wide;
  logic [CMPW-1:0]               cap_eff;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load     = (state == S_UPD) && out_free;
  assign hit      = |match_vec;
  assign refuse   = !hit && (req_mode || (req_now < lock_until));

  assign end_sum  = {1'b0, req_now} + {{(TW + 1 - lruc_pkg::LATW){1'b0}}, fetch_latency};
  assign lock_end = end_sum[TW] ? {TW{1'b1}} : end_sum[TW-1:0];

  // capacity zero acts as one, above the row size acts as the row size
  assign cap_wide = CMPW'(capacity);
  always_comb begin
    cap_eff = cap_wide;
    if (cap_wide == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_wide > CMPW'(N)) begin
      cap_eff = CMPW'(N);
    end
  end

  always_comb begin
    ctl.look  = accept;
    ctl.key   = lookup_id;
    ctl.upd   = load && !refuse;
    ctl.fetch = !hit;
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      // cells up to and including the hit one shift down
      assign seen[i]   = |match_vec[N-1:i];
      assign cap_ok[i] = (CMPW'(i) < cap_eff);
      if (i == 0) begin : g_head
        lruc_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctl        (ctl),
          .take       (ctl.fetch || seen[i]),
          .cap_ok     (cap_ok[i]),
          .prev_id    (req_id),
          .prev_valid (1'b1),
          .id         (id_vec[i]),
          .valid      (valid_vec[i]),
          .match      (match_vec[i])
        );
      end else begin : g_body
        lruc_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .ctl        (ctl),
          .take       (ctl.fetch || seen[i]),
          .cap_ok     (cap_ok[i]),
          .prev_id    (id_vec[i-1]),
          .prev_valid (valid_vec[i-1]),
          .id         (id_vec[i]),
          .valid      (valid_vec[i]),
          .match      (match_vec[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      lock_until    <= '0;
      capacity      <= lruc_pkg::CAP_RESET;
      fetch_latency <= lruc_pkg::LAT_RESET;
    end else begin
      if (wr_en) begin
        case (wr_index)
          lruc_pkg::REG_CAPACITY: capacity      <= wr_data[lruc_pkg::CAPW-1:0];
          lruc_pkg::REG_LATENCY:  fetch_latency <= wr_data;
          default: ;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
            if (!hit && !refuse) begin
              lock_until <= lock_end;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      req_mode <= mode;
      req_id   <= lookup_id;
      req_now  <= now;
    end
    if (load) begin
      if (hit) begin
        status     <= lruc_pkg::ST_HIT;
        ready_time <= req_now;
      end else if (refuse) begin
        status     <= lruc_pkg::ST_REFUSE;
        ready_time <= '0;
      end else begin
        status     <= lruc_pkg::ST_FETCH;
        ready_time <= lock_end;
      end
    end
  end

  // ids in the row are distinct, so at most one cell can match
  `LRUC_ASSERT_NOW(a_one_match, state == S_UPD, $onehot0(match_vec))
  // valid entries always form a prefix of the row
  `LRUC_ASSERT_NOW(a_prefix, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0)
  // a fetch leaves the new entry at the front
  `LRUC_ASSERT_NEXT(a_front, ctl.upd && ctl.fetch, valid_vec[0] && (id_vec[0] == req_id))
  // a fetch result reports the new lock end
  `LRUC_ASSERT_NEXT(a_lock, ctl.upd && ctl.fetch, lock_until == ready_time)

endmodule
`default_nettype wire
